// ===== sv/hgc_pkg.sv =====
// Shared types, constants and the arctangent table for the geofence distance check.
// Used by every module of the block; depends on nothing.
package hgc_pkg;

    // Word widths of the CORDIC rotation, vectoring and square-root datapaths.
    localparam int RW  = 34;
    localparam int VW  = 36;
    localparam int ZW  = 34;
    localparam int SQW = 64;
    localparam int SQ_STAGES = 32;

    typedef logic signed [RW-1:0]  rot_word_t;
    typedef logic signed [VW-1:0]  vec_word_t;
    typedef logic signed [ZW-1:0]  ang_t;
    typedef logic        [SQW-1:0] sq_word_t;
    typedef logic        [24:0]    dist_t;

    // Result item as it sits in the output buffer.
    typedef struct packed {
        logic  inside_res;
        dist_t distance_m;
    } result_t;

    // Degree and scaling constants (degrees times 1e7, radians in Q30).
    localparam logic signed [33:0] DEG_WRAP    = 34'sd3600000000;
    localparam logic signed [33:0] DEG_HALF    = 34'sd1800000000;
    localparam logic        [30:0] DEG_HALF_U  = 31'd1800000000;
    localparam logic        [30:0] DEG_QUARTER = 31'd900000000;
    localparam logic        [31:0] RAD_SCALE   = 32'd4024455254;
    localparam rot_word_t          INV_GAIN    = 34'sd652032874;
    localparam logic        [23:0] TWO_EARTH_R = 24'd12756274;
    localparam logic        [27:0] HALF_CIRC   = 28'd20037508;
    localparam logic        [57:0] ROUND_HALF  = 58'd536870912;

    // Arctangent of 2^-i in Q30 radians.
    function automatic logic [31:0] atan_q30(input int idx);
        logic [31:0] r;
        case (idx)
            0:  r = 32'h3243F6A8;
            1:  r = 32'h1DAC6705;
            2:  r = 32'h0FADBAFC;
            3:  r = 32'h07F56EA6;
            4:  r = 32'h03FEAB76;
            5:  r = 32'h01FFD55B;
            6:  r = 32'h00FFFAAA;
            7:  r = 32'h007FFF55;
            8:  r = 32'h003FFFEA;
            9:  r = 32'h001FFFFD;
            10: r = 32'h000FFFFF;
            11: r = 32'h0007FFFF;
            12: r = 32'h0003FFFF;
            13: r = 32'h0001FFFF;
            14: r = 32'h0000FFFF;
            15: r = 32'h00007FFF;
            16: r = 32'h00003FFF;
            17: r = 32'h00001FFF;
            18: r = 32'h00000FFF;
            19: r = 32'h000007FF;
            20: r = 32'h000003FF;
            21: r = 32'h000001FF;
            22: r = 32'h000000FF;
            23: r = 32'h0000007F;
            24: r = 32'h0000003F;
            25: r = 32'h0000001F;
            26: r = 32'h0000000F;
            27: r = 32'h00000008;
            28: r = 32'h00000004;
            29: r = 32'h00000002;
            30: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/hgc_if.sv =====
// Valid/ready channel interfaces for the input and result items.
// Depends on hgc_pkg for the distance type.
interface hgc_in_if import hgc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic signed [30:0] here_lat;
    logic signed [31:0] here_lng;
    logic signed [30:0] centre_lat;
    logic signed [31:0] centre_lng;

    modport source (output valid, here_lat, here_lng, centre_lat, centre_lng, input ready);
    modport sink   (input valid, here_lat, here_lng, centre_lat, centre_lng, output ready);
endinterface

interface hgc_out_if import hgc_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  inside_res;
    dist_t distance_m;

    modport source (output valid, inside_res, distance_m, input ready);
    modport sink   (input valid, inside_res, distance_m, output ready);
endinterface

// ===== sv/hgc_rot_cell.sv =====
// One rotation-mode CORDIC cell: turns (x, y) by the fixed angle of its stage.
// Depends on hgc_pkg for word types and the arctangent table.
module hgc_rot_cell import hgc_pkg::*; #(
    parameter int STAGE = 0
) (
    input  logic      clk,
    input  logic      en,
    input  rot_word_t x_in,
    input  rot_word_t y_in,
    input  ang_t      z_in,
    output rot_word_t x_out,
    output rot_word_t y_out,
    output ang_t      z_out
);

    localparam ang_t ATAN = ang_t'({2'b00, atan_q30(STAGE)});

    rot_word_t dx;
    rot_word_t dy;

    assign dx = x_in >>> STAGE;
    assign dy = y_in >>> STAGE;

    // Rotate toward zero residual angle.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (!z_in[ZW-1])
            begin
                x_out <= x_in - dy;
                y_out <= y_in + dx;
                z_out <= z_in - ATAN;
            end
            else
            begin
                x_out <= x_in + dy;
                y_out <= y_in - dx;
                z_out <= z_in + ATAN;
            end
        end
    end

endmodule

// ===== sv/hgc_vec_cell.sv =====
// One vectoring-mode CORDIC cell: drives y toward zero and sums the angle.
// Depends on hgc_pkg for word types and the arctangent table.
module hgc_vec_cell import hgc_pkg::*; #(
    parameter int STAGE = 0
) (
    input  logic      clk,
    input  logic      en,
    input  vec_word_t x_in,
    input  vec_word_t y_in,
    input  ang_t      z_in,
    output vec_word_t x_out,
    output vec_word_t y_out,
    output ang_t      z_out
);

    localparam ang_t ATAN = ang_t'({2'b00, atan_q30(STAGE)});

    vec_word_t dx;
    vec_word_t dy;

    assign dx = x_in >>> STAGE;
    assign dy = y_in >>> STAGE;

    // Rotate the vector onto the positive x axis.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (!y_in[VW-1])
            begin
                x_out <= x_in + dy;
                y_out <= y_in - dx;
                z_out <= z_in + ATAN;
            end
            else
            begin
                x_out <= x_in - dy;
                y_out <= y_in + dx;
                z_out <= z_in - ATAN;
            end
        end
    end

endmodule

// ===== sv/hgc_sqrt_cell.sv =====
// One shift-subtract square-root cell: decides one result bit per cycle while enabled.
// Depends on hgc_pkg for the word type.
module hgc_sqrt_cell import hgc_pkg::*; #(
    parameter int STAGE = 0
) (
    input  logic     clk,
    input  logic     en,
    input  sq_word_t rem_in,
    input  sq_word_t root_in,
    output sq_word_t rem_out,
    output sq_word_t root_out
);

    localparam sq_word_t BIT = sq_word_t'(1) << (62 - 2 * STAGE);

    sq_word_t trial;

    assign trial = root_in + BIT;

    // Subtract the trial value when it fits and set the result bit.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (rem_in >= trial)
            begin
                rem_out  <= rem_in - trial;
                root_out <= (root_in >> 1) + BIT;
            end
            else
            begin
                rem_out  <= rem_in;
                root_out <= root_in >> 1;
            end
        end
    end

endmodule

// ===== sv/haversine_geofence_check.sv =====
// Top level of the haversine geofence check: pipeline of CORDIC and root cells.
// Depends on hgc_pkg, hgc_if and the rot, vec and sqrt cell modules.
//
// Usage:
// Input items arrive on in_ch (valid/ready) with two positions in degrees
// times 1e7. Each yields exactly one result item on out_ch: the great-circle
// distance in whole metres, saturated at half the circumference, and a flag
// that is set when that distance is at most radius_m.
// radius_m is written through cfg_we/cfg_wdata; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// The datapath is a fully pipelined row of cells: five rotation CORDIC
// chains, a 32-cell square root, two vectoring chains in parallel, then one
// more vectoring chain. An item is accepted every cycle while the output
// buffer is not full. On its way to out_ch.valid an item passes a rotation
// chain, the square-root chain, a magnitude chain and the arctangent chain.
// Results land in a two-entry output buffer. When the receiver stalls, the
// buffer takes in up to two finished items; in_ch.ready drops only when it is full,
// and the whole pipeline then holds.
// Reset clears the pipeline valid bits and the buffer and sets radius_m to 3.
module haversine_geofence_check import hgc_pkg::*; #(
    parameter int CORDIC_STAGES = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    hgc_in_if.sink      in_ch,
    hgc_out_if.source   out_ch
);

    localparam int N      = CORDIC_STAGES;
    localparam int SQ_DLY = SQ_STAGES + 1;
    localparam int VN     = 3 * N + 37;
    localparam int P_G    = N + SQ_STAGES + 2;

    // Wrap a degree value into [-180, 180) degrees.
    function automatic logic signed [31:0] wrap_deg(input logic signed [33:0] d);
        logic signed [33:0] t;
        t = d;
        if (t >= DEG_HALF)
        begin
            t = t - DEG_WRAP;
        end
        else if (t < -DEG_HALF)
        begin
            t = t + DEG_WRAP;
        end
        return t[31:0];
    endfunction

    // Halved angle in Q30 radians.
    function automatic ang_t half_rad(input logic signed [31:0] w);
        logic signed [64:0] p;
        p = 65'(w) * $signed({33'b0, RAD_SCALE});
        return ang_t'($signed(p[63:32]));
    endfunction

    // Latitude in Q30 radians.
    function automatic ang_t lat_rad(input logic [30:0] a);
        logic [64:0] p;
        p = {34'b0, a} * {33'b0, RAD_SCALE};
        return ang_t'({1'b0, p[62:31]});
    endfunction

    // Control.
    logic [VN-1:0] vld_reg;
    logic          en;
    logic [15:0]   radius_reg;

    // Output buffer.
    result_t     buf_reg [0:1];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  cnt_reg;
    logic        full;
    logic        push;
    logic        pop;
    result_t     res_next;

    // Front end.
    logic signed [31:0] wd_lat_reg;
    logic signed [31:0] wd_lng_reg;
    logic signed [31:0] ws_lat_reg;
    logic        [30:0] fa1_reg;
    logic        [30:0] fa2_reg;
    logic        [1:0]  neg0_reg;
    logic        [30:0] abs1;
    logic        [30:0] abs2;
    ang_t               ang_reg [0:4];

    // Rotation chains: 0 latitude difference, 1 longitude difference,
    // 2 latitude sum, 3 cosine of here, 4 cosine of centre.
    rot_word_t rx [0:4][0:N];
    rot_word_t ry [0:4][0:N];
    ang_t      rz [0:4][0:N];
    logic [1:0] ng_reg [0:N];

    // Sine and cosine values waiting on the square root.
    rot_word_t sd_s1 [0:SQ_DLY];
    rot_word_t sd_s2 [0:SQ_DLY];
    rot_word_t sd_c2 [0:SQ_DLY];
    rot_word_t sd_s3 [0:SQ_DLY];

    rot_word_t   cos1;
    rot_word_t   cos2;
    logic signed [2*RW-1:0] cprod;
    sq_word_t    sq_rem [0:SQ_STAGES];
    sq_word_t    sq_root [0:SQ_STAGES];

    logic signed [RW+32:0] s2g;
    logic signed [RW+32:0] c2g;
    logic signed [RW+2:0]  s2g_sh;
    logic signed [RW+2:0]  c2g_sh;

    vec_word_t ax [0:1][0:N];
    vec_word_t ay [0:1][0:N];
    ang_t      az [0:1][0:N];
    vec_word_t bx [0:N];
    vec_word_t by [0:N];
    ang_t      bz [0:N];

    ang_t        theta;
    logic [57:0] dsum;
    logic [27:0] dq;
    dist_t       dist_reg;

    assign full        = (cnt_reg == 2'd2);
    assign en          = !full;
    assign in_ch.ready = en;
    assign push        = en && vld_reg[VN-1];
    assign pop         = out_ch.valid && out_ch.ready;

    // Radius register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 16'd3;
        end
        else if (cfg_we)
        begin
            radius_reg <= cfg_wdata;
        end
    end

    // Pipeline valid bits move together with the datapath.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[VN-2:0], in_ch.valid};
        end
    end

    // Angle wrapping and latitude folding for the cosine chains.
    assign abs1 = in_ch.here_lat[30] ? 31'(-in_ch.here_lat) : 31'(in_ch.here_lat);
    assign abs2 = in_ch.centre_lat[30] ? 31'(-in_ch.centre_lat) : 31'(in_ch.centre_lat);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wd_lat_reg <= wrap_deg(34'(in_ch.centre_lat) - 34'(in_ch.here_lat));
            wd_lng_reg <= wrap_deg(34'(in_ch.centre_lng) - 34'(in_ch.here_lng));
            ws_lat_reg <= wrap_deg(34'(in_ch.centre_lat) + 34'(in_ch.here_lat));
            fa1_reg    <= (abs1 > DEG_QUARTER) ? DEG_HALF_U - abs1 : abs1;
            fa2_reg    <= (abs2 > DEG_QUARTER) ? DEG_HALF_U - abs2 : abs2;
            neg0_reg   <= {abs2 > DEG_QUARTER, abs1 > DEG_QUARTER};
        end
    end

    // Scale to Q30 radians.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang_reg[0] <= half_rad(wd_lat_reg);
            ang_reg[1] <= half_rad(wd_lng_reg);
            ang_reg[2] <= half_rad(ws_lat_reg);
            ang_reg[3] <= lat_rad(fa1_reg);
            ang_reg[4] <= lat_rad(fa2_reg);
            ng_reg[0]  <= neg0_reg;
        end
    end

    // Rotation CORDIC chains.
    for (genvar c = 0; c < 5; c++)
    begin : g_rot
        assign rx[c][0] = INV_GAIN;
        assign ry[c][0] = '0;
        assign rz[c][0] = ang_reg[c];
        for (genvar k = 0; k < N; k++)
        begin : g_cell
            hgc_rot_cell #(.STAGE(k)) u_cell (
                .clk   (clk),
                .en    (en),
                .x_in  (rx[c][k]),
                .y_in  (ry[c][k]),
                .z_in  (rz[c][k]),
                .x_out (rx[c][k+1]),
                .y_out (ry[c][k+1]),
                .z_out (rz[c][k+1])
            );
        end
    end

    // Fold flags ride along with the cosine chains.
    for (genvar k = 0; k < N; k++)
    begin : g_ng
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ng_reg[k+1] <= ng_reg[k];
            end
        end
    end

    // Cosine product, clamped at zero.
    assign cos1  = ng_reg[N][0] ? -rx[3][N] : rx[3][N];
    assign cos2  = ng_reg[N][1] ? -rx[4][N] : rx[4][N];
    assign cprod = (2*RW)'(cos1) * (2*RW)'(cos2);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_rem[0] <= cprod[2*RW-1] ? '0 : cprod[SQW-1:0];
        end
    end
    assign sq_root[0] = '0;

    // Square-root chain.
    for (genvar j = 0; j < SQ_STAGES; j++)
    begin : g_sq
        hgc_sqrt_cell #(.STAGE(j)) u_cell (
            .clk      (clk),
            .en       (en),
            .rem_in   (sq_rem[j]),
            .root_in  (sq_root[j]),
            .rem_out  (sq_rem[j+1]),
            .root_out (sq_root[j+1])
        );
    end

    // Delay line for the sines and cosine used after the root.
    assign sd_s1[0] = ry[0][N];
    assign sd_s2[0] = ry[1][N];
    assign sd_c2[0] = rx[1][N];
    assign sd_s3[0] = ry[2][N];

    for (genvar j = 0; j < SQ_DLY; j++)
    begin : g_sd
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sd_s1[j+1] <= sd_s1[j];
                sd_s2[j+1] <= sd_s2[j];
                sd_c2[j+1] <= sd_c2[j];
                sd_s3[j+1] <= sd_s3[j];
            end
        end
    end

    // Scale the longitude terms by the root of the cosine product.
    assign s2g    = (RW+33)'(sd_s2[SQ_DLY]) * $signed({1'b0, sq_root[SQ_STAGES][31:0]});
    assign c2g    = (RW+33)'(sd_c2[SQ_DLY]) * $signed({1'b0, sq_root[SQ_STAGES][31:0]});
    assign s2g_sh = s2g[RW+32:30];
    assign c2g_sh = c2g[RW+32:30];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax[0][0] <= sd_s1[SQ_DLY][RW-1] ? VW'(-sd_s1[SQ_DLY]) : VW'(sd_s1[SQ_DLY]);
            ay[0][0] <= s2g_sh[RW+2] ? VW'(-s2g_sh) : VW'(s2g_sh);
            ax[1][0] <= sd_s3[SQ_DLY][RW-1] ? VW'(-sd_s3[SQ_DLY]) : VW'(sd_s3[SQ_DLY]);
            ay[1][0] <= c2g_sh[RW+2] ? VW'(-c2g_sh) : VW'(c2g_sh);
        end
    end

    // Magnitude chains for the haversine terms.
    for (genvar c = 0; c < 2; c++)
    begin : g_mag
        assign az[c][0] = '0;
        for (genvar k = 0; k < N; k++)
        begin : g_cell
            hgc_vec_cell #(.STAGE(k)) u_cell (
                .clk   (clk),
                .en    (en),
                .x_in  (ax[c][k]),
                .y_in  (ay[c][k]),
                .z_in  (az[c][k]),
                .x_out (ax[c][k+1]),
                .y_out (ay[c][k+1]),
                .z_out (az[c][k+1])
            );
        end
    end

    // Arctangent chain for the half central angle.
    assign bx[0] = ax[1][N];
    assign by[0] = ax[0][N];
    assign bz[0] = '0;

    for (genvar k = 0; k < N; k++)
    begin : g_atan
        hgc_vec_cell #(.STAGE(k)) u_cell (
            .clk   (clk),
            .en    (en),
            .x_in  (bx[k]),
            .y_in  (by[k]),
            .z_in  (bz[k]),
            .x_out (bx[k+1]),
            .y_out (by[k+1]),
            .z_out (bz[k+1])
        );
    end

    // Distance in metres with rounding and saturation.
    assign theta = bz[N][ZW-1] ? '0 : bz[N];
    assign dsum  = {34'b0, TWO_EARTH_R} * {24'b0, theta} + ROUND_HALF;
    assign dq    = dsum[57:30];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dist_reg <= (dq > HALF_CIRC) ? HALF_CIRC[24:0] : dq[24:0];
        end
    end

    assign res_next.distance_m = dist_reg;
    assign res_next.inside_res = (dist_reg <= {9'b0, radius_reg});

    // Two-entry output buffer.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    assign out_ch.valid      = (cnt_reg != 2'd0);
    assign out_ch.inside_res = buf_reg[rd_ptr_reg].inside_res;
    assign out_ch.distance_m = buf_reg[rd_ptr_reg].distance_m;

`ifndef SYNTHESIS
    // An accepted item enters the first pipeline stage.
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> vld_reg[0])
        else $error("accepted item missing from first stage");

    // Buffer never overflows or wraps.
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) |=> (cnt_reg != 2'd0) && (cnt_reg != 2'd3))
        else $error("output buffer count corrupted");

    // Stored distance never exceeds half the circumference.
    a_dist_sat: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (dist_reg <= HALF_CIRC[24:0]))
        else $error("distance above saturation limit");

    // Square root of a sub-unit product stays below 2.0 in Q30.
    a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[P_G] |-> (sq_root[SQ_STAGES][SQW-1:31] == '0))
        else $error("square root out of range");
`endif

endmodule
